@@ sv/dip_pkg.sv @@
// Shared types, codes and helpers for the dual-issue pairing fetch block.
package dip_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int STORE_DEPTH  = 256;
    localparam int IDX_W        = 8;
    localparam int SLOT_W       = 3;
    localparam int TAIL_W       = 4;
    localparam int LEN_W        = 9;

    localparam logic [1:0] KIND_ORD    = 2'd0;
    localparam logic [1:0] KIND_BRANCH = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    typedef struct packed {
        logic [4:0] rd;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [1:0] kind;
    } entry_t;

    typedef struct packed {
        entry_t           e;
        logic [IDX_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        slot_t cand;
        slot_t prior;
        logic  war_check;
    } hz_req_t;

    function automatic logic is_stopper(logic [1:0] k);
        return (k == KIND_BRANCH) || (k == KIND_END) || (k == KIND_NOP);
    endfunction

    function automatic slot_t nop_slot();
        slot_t s;
        s        = '0;
        s.e.kind = KIND_NOP;
        return s;
    endfunction

endpackage

@@ sv/dip_hazard.sv @@
// Register-hazard comparator between a candidate slot and one earlier slot.
module dip_hazard (
    input  dip_pkg::hz_req_t req,
    output logic             hazard
);
    logic waw_raw;
    logic war;

    assign waw_raw = (req.cand.e.rd == req.prior.e.rd) || (req.cand.e.rs == req.prior.e.rd)
                  || (req.cand.e.rt == req.prior.e.rd);
    assign war     = req.war_check && ((req.cand.e.rd == req.prior.e.rt)
                  || (req.cand.e.rd == req.prior.e.rs));
    assign hazard  = waw_raw || war;
endmodule

@@ sv/dual_issue_fetch_pairing_top.sv @@
// Top level of the dual-issue pairing fetch block.
// A load word writes one store entry in the cycle it is accepted. A fetch word walks the store
// from the program counter, one memory read and one fill step per entry, until eight slots are
// filled or the loaded length ends. It then runs the pairing check and, when the first two slots
// cannot pair and the first is no stopper, a hoist search on the hazard comparator, one slot pair
// per cycle. Last it clears the flags it passed over, one entry a cycle, unless the fetch is a
// stall. A result word waits while the previous one is held by out_stall.
// in_stall stays high for the whole fetch.
module dual_issue_fetch_pairing_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dip_pkg::LEN_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [7:0]                    load_index,
    input  logic [4:0]                    dest_reg,
    input  logic [4:0]                    src1_reg,
    input  logic [4:0]                    src2_reg,
    input  logic [1:0]                    kind,
    input  logic                          stall_req,
    input  logic                          mispredict,
    input  logic [7:0]                    branch_target,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          issued,
    output logic [7:0]                    first_index,
    output logic signed [31:0]            first_tag,
    output logic                          second_valid,
    output logic [7:0]                    second_index,
    output logic signed [31:0]            second_tag
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_PAIR = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_HAZ  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    dip_pkg::entry_t mem [dip_pkg::STORE_DEPTH];
    dip_pkg::entry_t rdata_reg;

    logic [2:0]                        state_reg;
    logic [dip_pkg::STORE_DEPTH-1:0]   flag_reg;
    logic [dip_pkg::LEN_W-1:0]         len_reg;
    logic [31:0]                       pc_reg;
    logic [31:0]                       last_pc_reg;
    logic [31:0]                       clr_reg;
    logic [31:0]                       tag_off_reg;
    logic [dip_pkg::LEN_W-1:0]         i_reg;
    logic [dip_pkg::TAIL_W-1:0]        tail_reg;
    logic [dip_pkg::TAIL_W-1:0]        w_reg;
    logic [dip_pkg::SLOT_W-1:0]        k_reg;
    logic                              pair_reg;
    logic                              hoist_reg;
    logic                              stall_q_reg;
    logic                              mis_q_reg;
    logic [7:0]                        tgt_q_reg;
    dip_pkg::slot_t                    slot_reg [dip_pkg::WINDOW_DEPTH];
    dip_pkg::slot_t                    second_reg;

    logic [dip_pkg::LEN_W-1:0] len_eff;
    logic                      accept;
    logic                      out_free;
    logic [31:0]               pc_new;
    logic [31:0]               hoist_addr;
    logic [dip_pkg::LEN_W:0]   i_inc;
    logic [dip_pkg::TAIL_W-1:0] tail_inc;
    dip_pkg::hz_req_t          hz_req;
    logic                      hz;
    dip_pkg::slot_t            s0;
    dip_pkg::slot_t            s1;

    assign len_eff  = (len_reg > dip_pkg::LEN_W'(dip_pkg::STORE_DEPTH))
                    ? dip_pkg::LEN_W'(dip_pkg::STORE_DEPTH) : len_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;
    assign s0       = slot_reg[0];
    assign s1       = slot_reg[1];
    assign pc_new   = pc_reg + ((pair_reg && !hoist_reg) ? 32'd2 : 32'd1);
    assign hoist_addr = pc_reg + 32'(w_reg);
    assign i_inc    = {1'b0, i_reg} + 1'b1;
    assign tail_inc = tail_reg + 1'b1;

    assign hz_req.cand      = slot_reg[w_reg[dip_pkg::SLOT_W-1:0]];
    assign hz_req.prior     = slot_reg[k_reg];
    assign hz_req.war_check = (k_reg > 3'd2);

    dip_hazard u_hazard (
        .req    (hz_req),
        .hazard (hz)
    );

    always_ff @(posedge clk)
    begin
        if (accept && !action)
        begin
            mem[load_index] <= '{rd: dest_reg, rs: src1_reg, rt: src2_reg, kind: kind};
        end
        rdata_reg <= mem[i_reg[dip_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            flag_reg    <= '0;
            len_reg     <= '0;
            pc_reg      <= '0;
            tag_off_reg <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (out_valid && !out_stall && (state_reg != S_OUT))
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!action)
                        begin
                            flag_reg[load_index] <= 1'b0;
                        end
                        else
                        begin
                            stall_q_reg <= stall_req;
                            mis_q_reg   <= mispredict;
                            tgt_q_reg   <= branch_target;
                            last_pc_reg <= pc_reg;
                            tail_reg    <= '0;
                            pair_reg    <= 1'b0;
                            hoist_reg   <= 1'b0;
                            for (int s = 0; s < dip_pkg::WINDOW_DEPTH; s++)
                            begin
                                slot_reg[s] <= dip_pkg::nop_slot();
                            end
                            i_reg <= pc_reg[dip_pkg::LEN_W-1:0];
                            if (pc_reg < 32'(len_eff))
                                state_reg <= S_RD;
                            else
                                state_reg <= S_PAIR;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_FILL;
                end
                S_FILL:
                begin
                    if (!flag_reg[i_reg[dip_pkg::IDX_W-1:0]])
                    begin
                        slot_reg[tail_reg[dip_pkg::SLOT_W-1:0]] <=
                            '{e: rdata_reg, idx: i_reg[dip_pkg::IDX_W-1:0]};
                        tail_reg <= tail_inc;
                    end
                    else if (tail_reg < dip_pkg::TAIL_W'(2))
                    begin
                        pc_reg <= pc_reg + 32'd1;
                    end
                    i_reg <= i_inc[dip_pkg::LEN_W-1:0];
                    if ((i_inc < {1'b0, len_eff}) &&
                        (flag_reg[i_reg[dip_pkg::IDX_W-1:0]] ||
                         (tail_inc < dip_pkg::TAIL_W'(dip_pkg::WINDOW_DEPTH))))
                        state_reg <= S_RD;
                    else
                        state_reg <= S_PAIR;
                end
                S_PAIR:
                begin
                    second_reg <= s1;
                    if (dip_pkg::is_stopper(s0.e.kind))
                    begin
                        state_reg <= S_CLR;
                    end
                    else if ((s1.e.rs != s0.e.rd) && (s1.e.rt != s0.e.rd) &&
                             (s1.e.kind != dip_pkg::KIND_END) &&
                             (s1.e.kind != dip_pkg::KIND_NOP))
                    begin
                        pair_reg  <= 1'b1;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        w_reg     <= dip_pkg::TAIL_W'(2);
                        state_reg <= S_SCAN;
                    end
                    clr_reg <= last_pc_reg;
                end
                S_SCAN:
                begin
                    if ((w_reg >= tail_reg) ||
                        dip_pkg::is_stopper(hz_req.cand.e.kind))
                    begin
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        k_reg     <= w_reg[dip_pkg::SLOT_W-1:0] - 1'b1;
                        state_reg <= S_HAZ;
                    end
                end
                S_HAZ:
                begin
                    if (hz)
                    begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else if (k_reg == '0)
                    begin
                        pair_reg   <= 1'b1;
                        hoist_reg  <= 1'b1;
                        second_reg <= hz_req.cand;
                        if (hoist_addr < 32'(dip_pkg::STORE_DEPTH))
                            flag_reg[hoist_addr[dip_pkg::IDX_W-1:0]] <= 1'b1;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                S_CLR:
                begin
                    // sweep flags of entries passed over, skipped on a stall
                    if (stall_q_reg || (clr_reg == pc_new))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (clr_reg < 32'(dip_pkg::STORE_DEPTH))
                            flag_reg[clr_reg[dip_pkg::IDX_W-1:0]] <= 1'b0;
                        clr_reg <= clr_reg + 32'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid    <= 1'b1;
                        issued       <= !stall_q_reg;
                        first_index  <= stall_q_reg ? '0 : s0.idx;
                        first_tag    <= stall_q_reg ? '0
                                      : $signed(32'(s0.idx) + tag_off_reg);
                        second_valid <= !stall_q_reg && pair_reg;
                        second_index <= (stall_q_reg || !pair_reg) ? '0 : second_reg.idx;
                        second_tag   <= (stall_q_reg || !pair_reg) ? '0
                                      : $signed(32'(second_reg.idx) + tag_off_reg);
                        if (!stall_q_reg)
                        begin
                            if (mis_q_reg)
                            begin
                                tag_off_reg <= tag_off_reg + pc_new - 32'(tgt_q_reg);
                                if (pc_new < 32'(dip_pkg::STORE_DEPTH))
                                    flag_reg[pc_new[dip_pkg::IDX_W-1:0]] <= 1'b0;
                                pc_reg <= 32'(tgt_q_reg);
                            end
                            else
                            begin
                                pc_reg <= pc_new;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_haz_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HAZ) |-> (w_reg < tail_reg) && (32'(k_reg) < 32'(w_reg)))
        else $error("hazard compare outside filled window");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_OUT))
        else $error("result word raised outside output step");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (tail_reg <= dip_pkg::TAIL_W'(dip_pkg::WINDOW_DEPTH)))
        else $error("window overfilled");

endmodule
